// ----- rtl/wlsm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wear-level slot manager package
// Item types, action and status codes, and the command and status bundles
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package wlsm_pkg;

  localparam int MAX_SLOTS = 16;
  localparam int SLOT_W    = 4;
  localparam int NUM_W     = SLOT_W + 1;
  localparam int CFG_W     = 5;
  localparam int CNT_W     = 32;

  localparam logic [CNT_W-1:0] CNT_MAX     = '1;
  localparam logic [CFG_W-1:0] SLOTS_RESET = CFG_W'(2);
  localparam logic [NUM_W-1:0] SLOTS_MIN   = NUM_W'(2);
  localparam logic [NUM_W-1:0] SLOTS_MAX   = NUM_W'(MAX_SLOTS);

  // action codes
  localparam logic [2:0] ACT_SCAN       = 3'd0;
  localparam logic [2:0] ACT_SCAN_DONE  = 3'd1;
  localparam logic [2:0] ACT_COMMIT_REQ = 3'd2;
  localparam logic [2:0] ACT_COMMIT_RPT = 3'd3;
  localparam logic [2:0] ACT_STATS      = 3'd4;

  // status codes
  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_PROGRAM  = 3'd1;
  localparam logic [2:0] ST_OVERFLOW = 3'd2;
  localparam logic [2:0] ST_FAILED   = 3'd3;
  localparam logic [2:0] ST_BAD      = 3'd4;

  typedef struct packed {
    logic [2:0]        action;
    logic [SLOT_W-1:0] slot_index;
    logic              header_valid;
    logic              data_valid;
    logic [CNT_W-1:0]  slot_generation;
    logic [CNT_W-1:0]  slot_erase_count;
    logic              erase_ok;
    logic              program_ok;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] target_slot;
    logic [CNT_W-1:0]  target_generation;
    logic [CNT_W-1:0]  target_erase_count;
    logic [SLOT_W-1:0] cur_slot;
    logic [CNT_W-1:0]  generation;
    logic [CNT_W-1:0]  fail_total;
    logic [CNT_W-1:0]  erase_min;
    logic [CNT_W-1:0]  erase_max;
    logic [CNT_W-1:0]  erase_sum;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic bad;
    logic sel_zero;
    logic mod_init;
    logic mod_step;
    logic walk_init;
    logic walk_issue;
    logic rd_sel;
    logic rd_pend;
    logic commit;
    logic report;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       sidx_bad;
    logic       found;
    logic       pending;
    logic       mod_done;
    logic       walk_last;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/wlsm_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wear-level slot manager datapath
// Erase count memory, slot state, slot walk with least-count search and
// stats accumulation, commit and report update, result assembly.
// ----------------------------------------------------------------------------
module wlsm_dp import wlsm_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire in_item_t         in_item,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_slots,
  input  wire dp_cmd_t          cmd,
  output dp_stat_t              stat,
  output out_item_t             res_item
);

  // configuration and slot state
  logic [CFG_W-1:0]  slots_cfg_r;
  logic [SLOT_W-1:0] active_r;
  logic [CNT_W-1:0]  gen_r;
  logic [CNT_W-1:0]  fail_r;
  logic              found_r;
  logic              pend_valid_r;
  logic [SLOT_W-1:0] pend_slot_r;
  logic [CNT_W-1:0]  pend_gen_r;

  // item and working registers
  in_item_t          item_r;
  logic [NUM_W-1:0]  mod_r;
  logic [SLOT_W-1:0] walk_idx_r;
  logic [NUM_W-1:0]  left_r;
  logic [SLOT_W-1:0] sel_r;
  logic [CNT_W-1:0]  best_r;
  logic [CNT_W-1:0]  min_r;
  logic [CNT_W-1:0]  max_r;
  logic [CNT_W-1:0]  tot_r;
  logic [2:0]        res_status_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic [CNT_W-1:0]  res_gen_r;
  logic [CNT_W-1:0]  res_cnt_r;

  // erase count memory
  logic [CNT_W-1:0]     mem [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] vld_r;
  logic [CNT_W-1:0]     raw_r;
  logic                 hit_r;
  logic                 rd_walk_r;
  logic [SLOT_W-1:0]    rd_tag_r;

  logic [NUM_W-1:0]  n_slots;
  logic              is_stats;
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic              we;
  logic [SLOT_W-1:0] wr_addr;
  logic [CNT_W-1:0]  wr_data;
  logic [CNT_W-1:0]  cnt_rd;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  gen_diff;
  logic              newer;
  logic              adopt;
  logic [CNT_W:0]    tot_sum;
  logic [SLOT_W-1:0] walk_start;
  logic [SLOT_W-1:0] walk_idx_nxt;
  logic [CNT_W-1:0]  req_gen;
  logic              req_ovf;
  logic              rpt_fail;

  always_comb begin
    if (slots_cfg_r > CFG_W'(MAX_SLOTS)) begin
      n_slots = SLOTS_MAX;
    end else if (NUM_W'(slots_cfg_r) < SLOTS_MIN) begin
      n_slots = SLOTS_MIN;
    end else begin
      n_slots = NUM_W'(slots_cfg_r);
    end
  end

  assign is_stats = (item_r.action == ACT_STATS);

  assign stat.action    = item_r.action;
  assign stat.sidx_bad  = ({1'b0, item_r.slot_index} >= n_slots);
  assign stat.found     = found_r;
  assign stat.pending   = pend_valid_r;
  assign stat.mod_done  = (mod_r < n_slots);
  assign stat.walk_last = (left_r == NUM_W'(1));

  assign cnt_rd  = hit_r ? raw_r : '0;
  assign cnt_inc = (cnt_rd == CNT_MAX) ? CNT_MAX : cnt_rd + CNT_W'(1);

  assign gen_diff = item_r.slot_generation - gen_r;
  assign newer    = (gen_diff != '0) && !gen_diff[CNT_W-1];
  assign adopt    = item_r.header_valid && item_r.data_valid && (!found_r || newer);

  assign tot_sum = {1'b0, tot_r} + {1'b0, cnt_rd};

  assign walk_start   = is_stats ? '0 : mod_r[SLOT_W-1:0];
  assign walk_idx_nxt = (({1'b0, walk_idx_r} + NUM_W'(1)) == n_slots) ? '0
                                                                      : walk_idx_r + SLOT_W'(1);

  assign req_gen  = (item_r.action == ACT_SCAN_DONE) ? CNT_W'(1) : gen_r + CNT_W'(1);
  assign req_ovf  = (cnt_rd == CNT_MAX);
  assign rpt_fail = !item_r.erase_ok || !item_r.program_ok;

  // one read port, one write port
  assign rd_en   = cmd.walk_issue || cmd.rd_sel || cmd.rd_pend;
  assign rd_addr = cmd.walk_issue ? walk_idx_r : (cmd.rd_sel ? sel_r : pend_slot_r);
  assign we      = (cmd.scan && item_r.header_valid) || (cmd.report && item_r.erase_ok);
  assign wr_addr = cmd.scan ? item_r.slot_index : pend_slot_r;
  assign wr_data = cmd.scan ? item_r.slot_erase_count : cnt_inc;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      raw_r <= mem[rd_addr];
      hit_r <= vld_r[rd_addr];
    end
    rd_tag_r <= walk_idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      rd_walk_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_walk_r <= cmd.walk_issue;
    end
  end

  // slot state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_cfg_r  <= SLOTS_RESET;
      active_r     <= '0;
      gen_r        <= '0;
      fail_r       <= '0;
      found_r      <= 1'b0;
      pend_valid_r <= 1'b0;
      pend_slot_r  <= '0;
      pend_gen_r   <= '0;
    end else begin
      if (cfg_we) begin
        slots_cfg_r <= cfg_slots;
      end
      if (cmd.scan && adopt) begin
        found_r  <= 1'b1;
        active_r <= item_r.slot_index;
        gen_r    <= item_r.slot_generation;
      end
      if (cmd.commit) begin
        pend_valid_r <= !req_ovf;
        pend_slot_r  <= sel_r;
        pend_gen_r   <= req_gen;
        if (req_ovf) begin
          fail_r <= fail_r + CNT_W'(1);
        end
      end
      if (cmd.report) begin
        pend_valid_r <= 1'b0;
        if (rpt_fail) begin
          fail_r <= fail_r + CNT_W'(1);
        end else begin
          active_r <= pend_slot_r;
          gen_r    <= pend_gen_r;
          found_r  <= 1'b1;
        end
      end
    end
  end

  // item, walk and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r       <= in_item;
      res_status_r <= ST_DONE;
      res_slot_r   <= '0;
      res_gen_r    <= '0;
      res_cnt_r    <= '0;
    end
    if (cmd.bad) begin
      res_status_r <= ST_BAD;
    end
    if (cmd.sel_zero) begin
      sel_r <= '0;
    end
    if (cmd.mod_init) begin
      mod_r <= {1'b0, active_r} + NUM_W'(1);
    end
    if (cmd.mod_step) begin
      mod_r <= mod_r - n_slots;
    end
    if (cmd.walk_init) begin
      walk_idx_r <= walk_start;
      left_r     <= n_slots;
      sel_r      <= walk_start;
      best_r     <= CNT_MAX;
      min_r      <= CNT_MAX;
      max_r      <= '0;
      tot_r      <= '0;
    end
    if (cmd.walk_issue) begin
      walk_idx_r <= walk_idx_nxt;
      left_r     <= left_r - NUM_W'(1);
    end
    // fold in the count read on the previous cycle
    if (rd_walk_r) begin
      if (is_stats) begin
        tot_r <= tot_sum[CNT_W] ? CNT_MAX : tot_sum[CNT_W-1:0];
        if (cnt_rd < min_r) begin
          min_r <= cnt_rd;
        end
        if (cnt_rd > max_r) begin
          max_r <= cnt_rd;
        end
      end else if ((rd_tag_r != active_r) && (cnt_rd < best_r)) begin
        best_r <= cnt_rd;
        sel_r  <= rd_tag_r;
      end
    end
    if (cmd.commit) begin
      if (req_ovf) begin
        res_status_r <= ST_OVERFLOW;
      end else begin
        res_status_r <= ST_PROGRAM;
        res_slot_r   <= sel_r;
        res_gen_r    <= req_gen;
        res_cnt_r    <= cnt_rd + CNT_W'(1);
      end
    end
    if (cmd.report && rpt_fail) begin
      res_status_r <= ST_FAILED;
    end
  end

  assign res_item.status             = res_status_r;
  assign res_item.target_slot        = res_slot_r;
  assign res_item.target_generation  = res_gen_r;
  assign res_item.target_erase_count = res_cnt_r;
  assign res_item.cur_slot           = active_r;
  assign res_item.generation         = gen_r;
  assign res_item.fail_total         = fail_r;
  assign res_item.erase_min          = is_stats ? min_r : '0;
  assign res_item.erase_max          = is_stats ? max_r : '0;
  assign res_item.erase_sum          = is_stats ? tot_r : '0;

endmodule
`default_nettype wire

// ----- rtl/wlsm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wear-level slot manager controller
// Sequences one item at a time: decode, slot walk, commit and report steps,
// and hand-off of the result to the output register.
// ----------------------------------------------------------------------------
module wlsm_ctrl import wlsm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic     out_free,
  output logic          emit,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DECODE = 9'b000000010,
    S_MOD    = 9'b000000100,
    S_WALK   = 9'b000001000,
    S_DRAIN  = 9'b000010000,
    S_CRD    = 9'b000100000,
    S_CMT    = 9'b001000000,
    S_RPT    = 9'b010000000,
    S_FIN    = 9'b100000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    emit      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.action)
          ACT_SCAN: begin
            if (stat.sidx_bad) begin
              cmd.bad = 1'b1;
            end else begin
              cmd.scan = 1'b1;
            end
            state_nxt = S_FIN;
          end
          ACT_SCAN_DONE: begin
            if (stat.found) begin
              state_nxt = S_FIN;
            end else begin
              cmd.sel_zero = 1'b1;
              state_nxt    = S_CRD;
            end
          end
          ACT_COMMIT_REQ: begin
            cmd.mod_init = 1'b1;
            state_nxt    = S_MOD;
          end
          ACT_COMMIT_RPT: begin
            if (stat.pending) begin
              cmd.rd_pend = 1'b1;
              state_nxt   = S_RPT;
            end else begin
              cmd.bad   = 1'b1;
              state_nxt = S_FIN;
            end
          end
          ACT_STATS: begin
            cmd.walk_init = 1'b1;
            state_nxt     = S_WALK;
          end
          default: begin
            cmd.bad   = 1'b1;
            state_nxt = S_FIN;
          end
        endcase
      end
      S_MOD: begin
        // reduce active + 1 to a slot in use, then start the walk there
        if (stat.mod_done) begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_WALK;
        end else begin
          cmd.mod_step = 1'b1;
        end
      end
      S_WALK: begin
        cmd.walk_issue = 1'b1;
        if (stat.walk_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = (stat.action == ACT_STATS) ? S_FIN : S_CRD;
      end
      S_CRD: begin
        cmd.rd_sel = 1'b1;
        state_nxt  = S_CMT;
      end
      S_CMT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_FIN;
      end
      S_RPT: begin
        cmd.report = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/wear_level_slot_manager.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wear-level slot manager
// Erase count bookkeeping and target slot choice for rotating flash slots.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one action item per handshake (scan, scan done, commit request,
//           commit report, stats query). One item is worked at a time.
//   out_* : exactly one result item per input item, held in an output
//           register until taken; the next input item is accepted while it
//           waits.
//   cfg_* : slots-in-use write, always ready; write only while idle.
// Steps per item, n = slots in use (2..16):
//   scan, scan done with a slot found, bad action: decode only
//   commit report: report step; scan done without a slot found: commit step
//   stats query: walk over n slots (one erase counter read per cycle)
//   commit request: reduce active+1 below n, walk, counter read, commit;
//   the walk reads one counter per cycle from the memory.
// A new item is taken only after the last one is handed off; a stalled
// receiver holds the finished item in the controller's final state.
// Reset clears all erase counts (per-slot valid bits), slot state and the
// output valid flag; the slots-in-use setting returns to 2.
// ----------------------------------------------------------------------------
module wear_level_slot_manager import wlsm_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_item,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_item,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CFG_W-1:0] cfg_slots
);

  dp_cmd_t   cmd;
  dp_stat_t  stat;
  out_item_t res_item;
  logic      emit;
  logic      out_free;
  logic      out_valid_r;
  out_item_t out_item_r;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  wlsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .emit     (emit),
    .stat     (stat),
    .cmd      (cmd)
  );

  wlsm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_slots (cfg_slots),
    .cmd       (cmd),
    .stat      (stat),
    .res_item  (res_item)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item accepted while one is in progress");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.status <= ST_BAD))
    else $error("undefined status code");

  a_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status != ST_PROGRAM)) |->
      ((out_item.target_slot == '0) && (out_item.target_erase_count == '0)))
    else $error("target fields set without a program target");

endmodule
`default_nettype wire
